FILE: hdl/occupancy_grid_beam_update_unit_defines.svh
// Assertion macros shared by the occupancy grid beam update RTL.
`ifndef OCCUPANCY_GRID_BEAM_UPDATE_UNIT_DEFINES_SVH
`define OCCUPANCY_GRID_BEAM_UPDATE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clock, quiet during reset.
`define OGBU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on clock, quiet during reset.
`define OGBU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/ogbu_pkg.sv
// Package: types, codes, reset values and helpers of the occupancy grid beam update.
package ogbu_pkg;

   localparam int DEF_GRID_WIDTH  = 32;
   localparam int DEF_GRID_HEIGHT = 32;

   // Signed coordinate width: covers grids up to 256 plus beam overshoot.
   localparam int CW = 10;

   // Transaction opcodes
   localparam logic OP_OBSERVE = 1'b0;
   localparam logic OP_QUERY   = 1'b1;

   // Cell classes
   localparam logic [1:0] CLASS_UNKNOWN  = 2'd0;
   localparam logic [1:0] CLASS_FREE     = 2'd1;
   localparam logic [1:0] CLASS_OCCUPIED = 2'd2;

   // Directions
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   // Beams in processing order
   localparam logic [1:0] BEAM_LEFT   = 2'd0;
   localparam logic [1:0] BEAM_CENTER = 2'd1;
   localparam logic [1:0] BEAM_RIGHT  = 2'd2;

   // CSR indexes
   localparam logic [2:0] REG_POSE_STEP      = 3'd0;
   localparam logic [2:0] REG_FREE_STEP      = 3'd1;
   localparam logic [2:0] REG_HIT_STEP       = 3'd2;
   localparam logic [2:0] REG_BELIEF_LIMIT   = 3'd3;
   localparam logic [2:0] REG_OCCUPIED_LEVEL = 3'd4;
   localparam logic [2:0] REG_FREE_LEVEL     = 3'd5;
   localparam logic [2:0] REG_MAX_BEAM_CELLS = 3'd6;

   // CSR reset values
   localparam logic [3:0]        RST_POSE_STEP      = 4'd4;
   localparam logic [3:0]        RST_FREE_STEP      = 4'd1;
   localparam logic [3:0]        RST_HIT_STEP       = 4'd3;
   localparam logic [3:0]        RST_BELIEF_LIMIT   = 4'd8;
   localparam logic [3:0]        RST_OCCUPIED_LEVEL = 4'd2;
   localparam logic signed [4:0] RST_FREE_LEVEL     = -5'sd2;
   localparam logic [3:0]        RST_MAX_BEAM_CELLS = 4'd8;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_WRITE,
      ST_QREAD,
      ST_QRESP
   } seq_state_type;

   // Free cells of a beam: Q4.4 rounded half up, capped.
   function automatic logic [3:0] beam_cells(input logic [7:0] reading,
                                             input logic [3:0] max_cells);
      logic [8:0] rounded;
      logic [4:0] cells;
      rounded = {1'b0, reading} + 9'd8;
      cells   = rounded[8:4];
      if (cells > {1'b0, max_cells}) begin
         return max_cells;
      end
      return cells[3:0];
   endfunction

   // Direction of a beam relative to the heading.
   function automatic logic [1:0] beam_dir(input logic [1:0] heading,
                                           input logic [1:0] beam);
      logic [1:0] offset;
      case (beam)
         BEAM_LEFT:  offset = 2'd3;
         BEAM_RIGHT: offset = 2'd1;
         default:    offset = 2'd0;
      endcase
      return heading + offset;
   endfunction

   function automatic logic signed [CW-1:0] dir_dx(input logic [1:0] dir);
      case (dir)
         DIR_RIGHT: return CW'(1);
         DIR_LEFT:  return -CW'(1);
         default:   return '0;
      endcase
   endfunction

   function automatic logic signed [CW-1:0] dir_dy(input logic [1:0] dir);
      case (dir)
         DIR_DOWN: return CW'(1);
         DIR_UP:   return -CW'(1);
         default:  return '0;
      endcase
   endfunction

endpackage

FILE: hdl/ogbu_req_if.sv
// Request channel interface: observe and query transactions.
interface ogbu_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [4:0] cell_x;
   logic [4:0] cell_y;
   logic [1:0] heading;
   logic [7:0] left_reading;
   logic [7:0] center_reading;
   logic [7:0] right_reading;
   logic       left_hit;
   logic       center_hit;
   logic       right_hit;

   modport source (
      output valid, op, cell_x, cell_y, heading,
             left_reading, center_reading, right_reading,
             left_hit, center_hit, right_hit,
      input  ready
   );

   modport sink (
      input  valid, op, cell_x, cell_y, heading,
             left_reading, center_reading, right_reading,
             left_hit, center_hit, right_hit,
      output ready
   );
endinterface

FILE: hdl/ogbu_rsp_if.sv
// Response channel interface: query results.
interface ogbu_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        cell_class;
   logic signed [4:0] belief_value;

   modport source (
      output valid, cell_class, belief_value,
      input  ready
   );

   modport sink (
      input  valid, cell_class, belief_value,
      output ready
   );
endinterface

FILE: hdl/ogbu_belief_mem.sv
// Belief counter memory: one write port, one registered read port.
module ogbu_belief_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic              clock,
   input  logic              we,
   input  logic [AW-1:0]     waddr,
   input  logic signed [4:0] wdata,
   input  logic              re,
   input  logic [AW-1:0]     raddr,
   output logic signed [4:0] rdata
);

   logic signed [4:0] mem [DEPTH];
   logic signed [4:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/ogbu_sat_alu.sv
// Shared saturating add and classifier for one belief counter.
module ogbu_sat_alu
   import ogbu_pkg::*;
(
   input  logic signed [4:0] operand,
   input  logic signed [4:0] amount,
   input  logic [3:0]        limit,
   input  logic [3:0]        occupied_level,
   input  logic signed [4:0] free_level,
   output logic signed [4:0] result,
   output logic [1:0]        cell_class
);

   logic signed [5:0] sum;
   logic signed [5:0] lim_pos;
   logic signed [5:0] lim_neg;
   logic signed [5:0] occ_level;
   logic signed [5:0] operand_ext;
   logic signed [5:0] free_ext;

   assign operand_ext = {operand[4], operand};
   assign sum         = operand_ext + {amount[4], amount};
   assign lim_pos     = signed'({2'b00, limit});
   assign lim_neg     = -lim_pos;
   assign occ_level   = signed'({2'b00, occupied_level});
   assign free_ext    = {free_level[4], free_level};

   always_comb begin
      if (sum > lim_pos) begin
         result = lim_pos[4:0];
      end else if (sum < lim_neg) begin
         result = lim_neg[4:0];
      end else begin
         result = sum[4:0];
      end
   end

   // occupied is tested first
   always_comb begin
      if (operand_ext >= occ_level) begin
         cell_class = CLASS_OCCUPIED;
      end else if (operand_ext <= free_ext) begin
         cell_class = CLASS_FREE;
      end else begin
         cell_class = CLASS_UNKNOWN;
      end
   end

endmodule

FILE: hdl/occupancy_grid_beam_update_unit.sv
// Top level: occupancy grid beam update unit with sequencer and CSRs.
//
// Keeps a GRID_WIDTH x GRID_HEIGHT grid of 5-bit signed saturating belief
// counters in one on-chip memory. After reset a clearing pass writes zero to
// every entry, one per cycle; req_chan.ready stays low until it is done. An
// observe transaction lowers the robot cell by pose_step, then casts the left,
// center and right beams in that order; each beam lowers the cells from the
// robot out to its rounded free distance by free_step and, on a hit short of
// max_beam_cells, raises the next cell by hit_step. Each touched cell is a
// read-modify-write through the one memory and the one shared saturating
// adder, a read state then a write state per cell. Cells off the grid still
// pass through both states but are not written. A query transaction reads
// the cell, then loads the response register and returns the counter and
// its class (occupied first, then free); a cell off the grid reads as unknown
// with counter zero. The response sits in an output register, so new
// requests are taken while it waits. CSRs are written through
// csr_we/csr_index/csr_wdata and must only be changed while idle.
`include "occupancy_grid_beam_update_unit_defines.svh"

module occupancy_grid_beam_update_unit
   import ogbu_pkg::*;
#(
   parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   ogbu_req_if.sink   req_chan,
   ogbu_rsp_if.source rsp_chan,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [4:0] csr_wdata
);

   localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [AW-1:0]        LAST_ADDR = AW'(DEPTH - 1);
   localparam logic signed [CW-1:0] GW_C      = CW'(GRID_WIDTH);
   localparam logic signed [CW-1:0] GH_C      = CW'(GRID_HEIGHT);

   // ---------------------------------------------------------------- CSRs
   logic [3:0]        pose_step_ff, free_step_ff, hit_step_ff, belief_limit_ff;
   logic [3:0]        occupied_level_ff, max_beam_cells_ff;
   logic signed [4:0] free_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pose_step_ff      <= RST_POSE_STEP;
         free_step_ff      <= RST_FREE_STEP;
         hit_step_ff       <= RST_HIT_STEP;
         belief_limit_ff   <= RST_BELIEF_LIMIT;
         occupied_level_ff <= RST_OCCUPIED_LEVEL;
         free_level_ff     <= RST_FREE_LEVEL;
         max_beam_cells_ff <= RST_MAX_BEAM_CELLS;
      end else if (csr_we) begin
         case (csr_index)
            REG_POSE_STEP:      pose_step_ff      <= csr_wdata[3:0];
            REG_FREE_STEP:      free_step_ff      <= csr_wdata[3:0];
            REG_HIT_STEP:       hit_step_ff       <= csr_wdata[3:0];
            REG_BELIEF_LIMIT:   belief_limit_ff   <= csr_wdata[3:0];
            REG_OCCUPIED_LEVEL: occupied_level_ff <= csr_wdata[3:0];
            REG_FREE_LEVEL:     free_level_ff     <= signed'(csr_wdata);
            REG_MAX_BEAM_CELLS: max_beam_cells_ff <= csr_wdata[3:0];
            default: ;  // index beyond the list: ignored
         endcase
      end
   end

   // ------------------------------------------------------ sequencer state
   seq_state_type state_ff, state_in;

   logic [AW-1:0] clear_addr_ff, clear_addr_in;

   // latched transaction
   logic       op_ff, op_in;
   logic [4:0] robot_x_ff, robot_x_in, robot_y_ff, robot_y_in;
   logic [1:0] heading_ff, heading_in;
   logic [7:0] left_reading_ff, center_reading_ff, right_reading_ff;
   logic [7:0] left_reading_in, center_reading_in, right_reading_in;
   logic [2:0] hits_ff, hits_in;  // bit per beam: left, center, right

   // walk position
   logic signed [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic       pose_ff, pose_in;   // current cell is the pose update
   logic       hit_ff, hit_in;     // current cell is a beam's wall cell
   logic [1:0] beam_ff, beam_in;
   logic [4:0] step_ff, step_in;   // 0..15 along the beam

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_class_ff, rsp_class_in;
   logic signed [4:0] rsp_value_ff, rsp_value_in;

   // control strobes
   logic req_ready, req_take, mem_re, mem_we, rsp_load, walk_step;

   // ----------------------------------------------------- walk bookkeeping
   logic [7:0]        cur_reading;
   logic              cur_hit;
   logic [3:0]        cur_cells;
   logic [1:0]        cur_dir;
   logic              cell_on_grid;
   logic              more_free, take_hit, last_cell;
   logic signed [4:0] amount;
   logic [AW-1:0]     cell_addr;

   always_comb begin
      case (beam_ff)
         BEAM_LEFT: begin
            cur_reading = left_reading_ff;
            cur_hit     = hits_ff[0];
         end
         BEAM_CENTER: begin
            cur_reading = center_reading_ff;
            cur_hit     = hits_ff[1];
         end
         default: begin
            cur_reading = right_reading_ff;
            cur_hit     = hits_ff[2];
         end
      endcase
   end

   assign cur_cells = beam_cells(cur_reading, max_beam_cells_ff);
   assign cur_dir   = beam_dir(heading_ff, beam_ff);

   assign cell_on_grid = !cx_ff[CW-1] && (cx_ff < GW_C) && !cy_ff[CW-1] && (cy_ff < GH_C);

   // only meaningful while the cell is on the grid
   assign cell_addr = AW'(32'(cy_ff[CW-2:0]) * 32'(GRID_WIDTH) + 32'(cx_ff[CW-2:0]));

   assign more_free = !pose_ff && !hit_ff && (step_ff < {1'b0, cur_cells});
   assign take_hit  = !pose_ff && !hit_ff && !more_free && cur_hit &&
                      (cur_cells < max_beam_cells_ff);
   assign last_cell = !pose_ff && !more_free && !take_hit && (beam_ff == BEAM_RIGHT);

   always_comb begin
      if (pose_ff) begin
         amount = -signed'({1'b0, pose_step_ff});
      end else if (hit_ff) begin
         amount = signed'({1'b0, hit_step_ff});
      end else begin
         amount = -signed'({1'b0, free_step_ff});
      end
   end

   // ------------------------------------------------ shared unit and memory
   logic signed [4:0] mem_rdata, alu_result, mem_wdata;
   logic [1:0]        alu_class;
   logic [AW-1:0]     mem_waddr;

   ogbu_sat_alu u_alu (
      .operand        (mem_rdata),
      .amount         (amount),
      .limit          (belief_limit_ff),
      .occupied_level (occupied_level_ff),
      .free_level     (free_level_ff),
      .result         (alu_result),
      .cell_class     (alu_class)
   );

   assign mem_waddr = (state_ff == ST_CLEAR) ? clear_addr_ff : cell_addr;
   assign mem_wdata = (state_ff == ST_CLEAR) ? 5'sd0 : alu_result;

   ogbu_belief_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (cell_addr),
      .rdata (mem_rdata)
   );

   // ------------------------------------------------------------ next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = (req_chan.op == OP_QUERY) ? ST_QREAD : ST_READ;
            end
         end
         ST_READ:  state_in = ST_WRITE;
         ST_WRITE: state_in = last_cell ? ST_IDLE : ST_READ;
         ST_QREAD: state_in = ST_QRESP;
         ST_QRESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // -------------------------------------------------------------- outputs
   always_comb begin
      req_ready = 1'b0;
      mem_re    = 1'b0;
      mem_we    = 1'b0;
      rsp_load  = 1'b0;
      walk_step = 1'b0;
      case (state_ff)
         ST_CLEAR: mem_we = 1'b1;
         ST_IDLE:  req_ready = 1'b1;
         ST_READ:  mem_re = cell_on_grid;
         ST_WRITE: begin
            mem_we    = cell_on_grid;
            walk_step = 1'b1;
         end
         ST_QREAD: mem_re = cell_on_grid;
         ST_QRESP: rsp_load = !rsp_valid_ff || rsp_chan.ready;
         default: ;
      endcase
   end

   assign req_take = req_ready && req_chan.valid;

   // -------------------------------------------------------- datapath next
   always_comb begin
      clear_addr_in     = clear_addr_ff;
      op_in             = op_ff;
      robot_x_in        = robot_x_ff;
      robot_y_in        = robot_y_ff;
      heading_in        = heading_ff;
      left_reading_in   = left_reading_ff;
      center_reading_in = center_reading_ff;
      right_reading_in  = right_reading_ff;
      hits_in           = hits_ff;
      cx_in             = cx_ff;
      cy_in             = cy_ff;
      pose_in           = pose_ff;
      hit_in            = hit_ff;
      beam_in           = beam_ff;
      step_in           = step_ff;

      if (state_ff == ST_CLEAR) begin
         clear_addr_in = clear_addr_ff + AW'(1);
      end

      if (req_take) begin
         op_in             = req_chan.op;
         robot_x_in        = req_chan.cell_x;
         robot_y_in        = req_chan.cell_y;
         heading_in        = req_chan.heading;
         left_reading_in   = req_chan.left_reading;
         center_reading_in = req_chan.center_reading;
         right_reading_in  = req_chan.right_reading;
         hits_in = {req_chan.right_hit, req_chan.center_hit, req_chan.left_hit};
         cx_in   = signed'(CW'(req_chan.cell_x));
         cy_in   = signed'(CW'(req_chan.cell_y));
         pose_in = 1'b1;
         hit_in  = 1'b0;
         beam_in = BEAM_LEFT;
         step_in = '0;
      end else if (walk_step) begin
         if (pose_ff) begin
            // first beam starts on the robot cell again
            pose_in = 1'b0;
         end else if (more_free || take_hit) begin
            hit_in  = take_hit;
            step_in = step_ff + 5'd1;
            cx_in   = cx_ff + dir_dx(cur_dir);
            cy_in   = cy_ff + dir_dy(cur_dir);
         end else begin
            hit_in  = 1'b0;
            beam_in = beam_ff + 2'd1;
            step_in = '0;
            cx_in   = signed'(CW'(robot_x_ff));
            cy_in   = signed'(CW'(robot_y_ff));
         end
      end
   end

   // response register
   always_comb begin
      rsp_class_in = rsp_class_ff;
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_class_in = cell_on_grid ? alu_class : CLASS_UNKNOWN;
         rsp_value_in = cell_on_grid ? mem_rdata : 5'sd0;
      end
   end

   // -------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         pose_ff       <= 1'b0;
         hit_ff        <= 1'b0;
         beam_ff       <= BEAM_LEFT;
         step_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
         pose_ff       <= pose_in;
         hit_ff        <= hit_in;
         beam_ff       <= beam_in;
         step_ff       <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff             <= op_in;
      robot_x_ff        <= robot_x_in;
      robot_y_ff        <= robot_y_in;
      heading_ff        <= heading_in;
      left_reading_ff   <= left_reading_in;
      center_reading_ff <= center_reading_in;
      right_reading_ff  <= right_reading_in;
      hits_ff           <= hits_in;
      cx_ff             <= cx_in;
      cy_ff             <= cy_in;
      rsp_class_ff      <= rsp_class_in;
      rsp_value_ff      <= rsp_value_in;
   end

   // ---------------------------------------------------------------- ports
   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.cell_class   = rsp_class_ff;
   assign rsp_chan.belief_value = rsp_value_ff;

   // ----------------------------------------------------------- assertions
   `OGBU_ASSERT_NEXT(a_busy_after_take, req_take, !req_chan.ready, "ready after accept")
   `OGBU_ASSERT_NOW(a_we_states, mem_we, (state_ff == ST_CLEAR) || (state_ff == ST_WRITE), "stray memory write")
   `OGBU_ASSERT_NOW(a_clear_blocks, state_ff == ST_CLEAR, !req_chan.ready, "request taken during clear")
   `OGBU_ASSERT_NEXT(a_query_responds, req_take && (req_chan.op == OP_QUERY), !rsp_valid_ff || (op_ff == OP_QUERY), "query latch lost")
   `OGBU_ASSERT_NOW(a_rsp_from_query, $rose(rsp_chan.valid), $past(state_ff) == ST_QRESP, "response without query")

endmodule

FILE: verif/occupancy_grid_beam_update_unit_checker.sv
// Checker: shadow belief grid and CSRs, predicts query results and compares them.
`timescale 1ns / 1ps

module occupancy_grid_beam_update_unit_checker
   import ogbu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ogbu_req_if        req_mon,
   ogbu_rsp_if        rsp_mon,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [4:0] csr_wdata,
   output int         fail_count,
   output int         pending_count,
   output int         checked_count
);

   localparam int GRID_W = DEF_GRID_WIDTH;
   localparam int GRID_H = DEF_GRID_HEIGHT;

   typedef struct packed {
      logic [1:0]        cell_class;
      logic signed [4:0] belief_value;
   } cell_readout_type;

   logic signed [4:0] belief_shadow [GRID_W * GRID_H];
   logic [3:0]        pose_step_q;
   logic [3:0]        free_step_q;
   logic [3:0]        hit_step_q;
   logic [3:0]        limit_q;
   logic [3:0]        occupied_level_q;
   logic signed [4:0] free_level_q;
   logic [3:0]        max_cells_q;

   // Query results owed by the block, oldest first.
   cell_readout_type readouts_owed [$];

   function automatic bit on_grid(input int x, input int y);
      return x >= 0 && x < GRID_W && y >= 0 && y < GRID_H;
   endfunction

   // Saturating update of one counter; off-grid cells are skipped.
   task automatic nudge_cell(input int x, input int y, input int amount);
      int lim;
      int sum;
      if (!on_grid(x, y)) begin
         return;
      end
      lim = int'(limit_q);
      sum = int'(belief_shadow[y * GRID_W + x]) + amount;
      if (sum > lim) begin
         sum = lim;
      end
      if (sum < -lim) begin
         sum = -lim;
      end
      belief_shadow[y * GRID_W + x] = sum[4:0];
   endtask

   task automatic trace_beam(input int x, input int y, input logic [1:0] dir,
                             input logic [7:0] reading, input logic hit);
      int cells;
      int dx;
      int dy;
      int s;
      cells = (int'(reading) + 8) >> 4;
      if (cells > int'(max_cells_q)) begin
         cells = int'(max_cells_q);
      end
      dx = 0;
      dy = 0;
      case (dir)
         DIR_UP:    dy = -1;
         DIR_RIGHT: dx = 1;
         DIR_DOWN:  dy = 1;
         default:   dx = -1;
      endcase
      for (s = 0; s <= cells; s++) begin
         nudge_cell(x + dx * s, y + dy * s, -int'(free_step_q));
      end
      if (hit && cells < int'(max_cells_q)) begin
         nudge_cell(x + dx * (cells + 1), y + dy * (cells + 1), int'(hit_step_q));
      end
   endtask

   function automatic cell_readout_type read_cell(input int x, input int y);
      cell_readout_type r;
      r.cell_class   = CLASS_UNKNOWN;
      r.belief_value = '0;
      if (on_grid(x, y)) begin
         r.belief_value = belief_shadow[y * GRID_W + x];
         if (int'(r.belief_value) >= int'(occupied_level_q)) begin
            r.cell_class = CLASS_OCCUPIED;
         end else if (int'(r.belief_value) <= int'(free_level_q)) begin
            r.cell_class = CLASS_FREE;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      cell_readout_type due;
      int               x;
      int               y;
      if (reset) begin
         foreach (belief_shadow[i]) begin
            belief_shadow[i] = '0;
         end
         pose_step_q      = RST_POSE_STEP;
         free_step_q      = RST_FREE_STEP;
         hit_step_q       = RST_HIT_STEP;
         limit_q          = RST_BELIEF_LIMIT;
         occupied_level_q = RST_OCCUPIED_LEVEL;
         free_level_q     = RST_FREE_LEVEL;
         max_cells_q      = RST_MAX_BEAM_CELLS;
         readouts_owed.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_POSE_STEP:      pose_step_q      = csr_wdata[3:0];
               REG_FREE_STEP:      free_step_q      = csr_wdata[3:0];
               REG_HIT_STEP:       hit_step_q       = csr_wdata[3:0];
               REG_BELIEF_LIMIT:   limit_q          = csr_wdata[3:0];
               REG_OCCUPIED_LEVEL: occupied_level_q = csr_wdata[3:0];
               REG_FREE_LEVEL:     free_level_q     = csr_wdata;
               REG_MAX_BEAM_CELLS: max_cells_q      = csr_wdata[3:0];
               default: ;
            endcase
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (readouts_owed.size() == 0) begin
               fail_count++;
               $error("response with no query outstanding: cell_class %0d belief_value %0d",
                      rsp_mon.cell_class, rsp_mon.belief_value);
            end else begin
               due = readouts_owed.pop_front();
               checked_count++;
               if (rsp_mon.cell_class !== due.cell_class) begin
                  fail_count++;
                  $error("cell_class: expected %0d, got %0d",
                         due.cell_class, rsp_mon.cell_class);
               end
               if (rsp_mon.belief_value !== due.belief_value) begin
                  fail_count++;
                  $error("belief_value: expected %0d, got %0d",
                         due.belief_value, rsp_mon.belief_value);
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            x = int'(req_mon.cell_x);
            y = int'(req_mon.cell_y);
            if (req_mon.op == OP_QUERY) begin
               readouts_owed.insert(readouts_owed.size(), read_cell(x, y));
            end else begin
               nudge_cell(x, y, -int'(pose_step_q));
               trace_beam(x, y, req_mon.heading + 2'd3, req_mon.left_reading,
                          req_mon.left_hit);
               trace_beam(x, y, req_mon.heading, req_mon.center_reading,
                          req_mon.center_hit);
               trace_beam(x, y, req_mon.heading + 2'd1, req_mon.right_reading,
                          req_mon.right_hit);
            end
         end
      end
      pending_count = readouts_owed.size();
   end

endmodule

FILE: verif/occupancy_grid_beam_update_unit_test.sv
// Testbench top: clock, reset, CSR phases and request/response traffic for the beam update unit.
`timescale 1ns / 1ps

module occupancy_grid_beam_update_unit_test;
   import ogbu_pkg::*;

   // Reset is followed by a clearing pass over the whole grid with req ready low;
   // that is the longest stretch without a transaction in a correct run.
   localparam int WATCHDOG_LIMIT = 5000;
   // Covers the longest observe: its read-modify-write of every touched cell plus its acceptance.
   localparam int DRAIN_CYCLES   = 110;
   localparam int PHASES         = 10;
   localparam int ITEMS_PER_PHASE = 188;
   // No register lives at this index; a write there must change nothing.
   localparam logic [2:0] REG_UNMAPPED = 3'd7;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic       op;
      logic [4:0] cell_x;
      logic [4:0] cell_y;
      logic [1:0] heading;
      logic [7:0] left_reading;
      logic [7:0] center_reading;
      logic [7:0] right_reading;
      logic       left_hit;
      logic       center_hit;
      logic       right_hit;
   } beam_request_type;

   // Raw CSR write data; bit 4 of the 4-bit registers is deliberately exercised.
   typedef struct packed {
      logic [4:0] pose_step;
      logic [4:0] free_step;
      logic [4:0] hit_step;
      logic [4:0] belief_limit;
      logic [4:0] occupied_level;
      logic [4:0] free_level;
      logic [4:0] max_beam_cells;
   } csr_values_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic [2:0] csr_index;
   logic [4:0] csr_wdata;

   idle_mode_type idle_mode = IDLE_NONE;
   int         fail_count;
   int         pending_count;
   int         checked_count;
   int         observe_count = 0;
   int         query_count = 0;

   ogbu_req_if req_chan ();
   ogbu_rsp_if rsp_chan ();

   occupancy_grid_beam_update_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   occupancy_grid_beam_update_unit_checker grid_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- idling

   function automatic bit sender_waits();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(0, 99) < 83;
         IDLE_BOTH:   return $urandom_range(0, 99) < 15;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_takes();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(0, 99) >= 83;
         IDLE_BOTH:     return $urandom_range(0, 99) >= 15;
         default:       return 1'b1;
      endcase
   endfunction

   // Response side: ready redrawn every falling edge, whether or not valid is up.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= receiver_takes();
      end
   end

   // ------------------------------------------------------------- items

   // Unused fields of a query get random values; the block must ignore them.
   function automatic beam_request_type query_at(input logic [4:0] x, input logic [4:0] y);
      beam_request_type t;
      logic [63:0]      raw;
      raw      = {$urandom, $urandom};
      t        = raw[$bits(beam_request_type)-1:0];
      t.op     = OP_QUERY;
      t.cell_x = x;
      t.cell_y = y;
      return t;
   endfunction

   function automatic beam_request_type observe_at(input logic [4:0] x, input logic [4:0] y,
                                                   input logic [1:0] heading,
                                                   input logic [7:0] left_r,
                                                   input logic [7:0] center_r,
                                                   input logic [7:0] right_r,
                                                   input logic left_h, input logic center_h,
                                                   input logic right_h);
      beam_request_type t;
      t.op             = OP_OBSERVE;
      t.cell_x         = x;
      t.cell_y         = y;
      t.heading        = heading;
      t.left_reading   = left_r;
      t.center_reading = center_r;
      t.right_reading  = right_r;
      t.left_hit       = left_h;
      t.center_hit     = center_h;
      t.right_hit      = right_h;
      return t;
   endfunction

   // Mostly short beams, sometimes anything up to 15.9375 cells.
   function automatic logic [7:0] random_reading();
      if ($urandom_range(0, 9) < 6) begin
         return 8'($urandom_range(0, 95));
      end
      return 8'($urandom);
   endfunction

   // Traffic clusters around a hot spot so that queries land on touched cells;
   // the rest goes anywhere, with a share pinned to the grid border.
   function automatic logic [4:0] random_coord(input int hot);
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         return 5'((hot + $urandom_range(0, 5)) % 32);
      end else if (pick < 9) begin
         return 5'($urandom_range(0, 31));
      end
      return $urandom_range(0, 1) ? 5'd31 : 5'd0;
   endfunction

   function automatic beam_request_type random_request(input int hot_x, input int hot_y);
      beam_request_type t;
      logic [63:0]      raw;
      raw              = {$urandom, $urandom};
      t                = raw[$bits(beam_request_type)-1:0];
      t.op             = ($urandom_range(0, 99) < 40) ? OP_QUERY : OP_OBSERVE;
      t.cell_x         = random_coord(hot_x);
      t.cell_y         = random_coord(hot_y);
      t.left_reading   = random_reading();
      t.center_reading = random_reading();
      t.right_reading  = random_reading();
      return t;
   endfunction

   // Present one transaction and hold it until the block takes it. Valid is
   // only lowered when an idle cycle is drawn, never between back-to-back items.
   task automatic send_request(input beam_request_type t);
      @(negedge clock);
      while (sender_waits()) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.op             <= t.op;
      req_chan.cell_x         <= t.cell_x;
      req_chan.cell_y         <= t.cell_y;
      req_chan.heading        <= t.heading;
      req_chan.left_reading   <= t.left_reading;
      req_chan.center_reading <= t.center_reading;
      req_chan.right_reading  <= t.right_reading;
      req_chan.left_hit       <= t.left_hit;
      req_chan.center_hit     <= t.center_hit;
      req_chan.right_hit      <= t.right_hit;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      if (t.op == OP_QUERY) begin
         query_count++;
      end else begin
         observe_count++;
      end
   endtask

   // Drop valid, collect every owed result, then let a trailing observe finish.
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_count != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ---------------------------------------------------------------- CSRs

   task automatic write_csr(input logic [2:0] index, input logic [4:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
   endtask

   task automatic program_csrs(input csr_values_type s);
      write_csr(REG_POSE_STEP, s.pose_step);
      write_csr(REG_FREE_STEP, s.free_step);
      write_csr(REG_HIT_STEP, s.hit_step);
      write_csr(REG_BELIEF_LIMIT, s.belief_limit);
      write_csr(REG_OCCUPIED_LEVEL, s.occupied_level);
      write_csr(REG_FREE_LEVEL, s.free_level);
      write_csr(REG_MAX_BEAM_CELLS, s.max_beam_cells);
   endtask

   function automatic csr_values_type make_settings(input logic [4:0] pose,
                                                    input logic [4:0] free,
                                                    input logic [4:0] hit,
                                                    input logic [4:0] limit,
                                                    input logic [4:0] occupied,
                                                    input logic [4:0] free_lvl,
                                                    input logic [4:0] max_cells);
      csr_values_type s;
      s.pose_step      = pose;
      s.free_step      = free;
      s.hit_step       = hit;
      s.belief_limit   = limit;
      s.occupied_level = occupied;
      s.free_level     = free_lvl;
      s.max_beam_cells = max_cells;
      return s;
   endfunction

   function automatic csr_values_type settings_for_phase(input int phase);
      case (phase)
         // everything at the top of its range
         1: return make_settings(5'd15, 5'd15, 5'd15, 5'd15, 5'd15, -5'sd15, 5'd15);
         // everything at the bottom: steps of zero still saturate to the lowered limit
         2: return make_settings(5'd0, 5'd0, 5'd0, 5'd1, 5'd1, -5'sd1, 5'd0);
         // wall-heavy: strong hits, long beams
         3: return make_settings(5'd1, 5'd1, 5'd15, 5'd12, 5'd5, -5'sd5, 5'd15);
         // bit 4 set on 4-bit registers (masked off): zero limit, occupied level 0,
         // free level 0
         4: return make_settings(5'h13, 5'h12, 5'h1F, 5'h10, 5'h10, 5'd0, 5'h1C);
         // positive free level: classes overlap, occupied wins
         5: return make_settings(5'd0, 5'd2, 5'd4, 5'd15, 5'd3, 5'd3, 5'd4);
         // limit dropped from 15 to 3 while counters sit far beyond it
         6: return make_settings(5'd4, 5'd1, 5'd3, 5'd3, 5'd2, -5'sd2, 5'd8);
         default: return make_settings(5'($urandom_range(0, 15)), 5'($urandom_range(0, 15)),
                                       5'($urandom_range(0, 15)), 5'($urandom_range(1, 15)),
                                       5'($urandom_range(1, 15)),
                                       5'(-int'($urandom_range(1, 15))),
                                       5'($urandom_range(0, 15)));
      endcase
   endfunction

   // ------------------------------------------------------------ stimulus

   initial begin : stimulus
      int hot_x;
      int hot_y;
      int phase;

      reset                   = 1'b1;
      csr_we                  = 1'b0;
      csr_index               = REG_POSE_STEP;
      csr_wdata               = '0;
      req_chan.valid          = 1'b0;
      req_chan.op             = OP_OBSERVE;
      req_chan.cell_x         = '0;
      req_chan.cell_y         = '0;
      req_chan.heading        = DIR_UP;
      req_chan.left_reading   = '0;
      req_chan.center_reading = '0;
      req_chan.right_reading  = '0;
      req_chan.left_hit       = 1'b0;
      req_chan.center_hit     = 1'b0;
      req_chan.right_hit      = 1'b0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, reset register values, no idling.
      // Freshly cleared grid reads zero / unknown.
      send_request(query_at(5'd0, 5'd0));
      send_request(query_at(5'd31, 5'd31));
      // Corner robot, longest readings with walls: left and center beams leave
      // the grid at once, the right beam is capped so its wall is dropped.
      send_request(observe_at(5'd0, 5'd0, DIR_UP, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1));
      send_request(query_at(5'd0, 5'd0));
      send_request(query_at(5'd8, 5'd0));
      // Opposite corner facing down: walls off the grid are skipped.
      send_request(observe_at(5'd31, 5'd31, DIR_DOWN, 8'h08, 8'h07, 8'h17, 1'b1, 1'b1, 1'b1));
      // Rounding: 0.4375 -> 0 cells, 0.5 -> 1, 1.5 -> 2.
      send_request(observe_at(5'd16, 5'd16, DIR_RIGHT, 8'h07, 8'h08, 8'h18, 1'b1, 1'b1, 1'b1));
      send_request(query_at(5'd16, 5'd15));
      send_request(query_at(5'd17, 5'd16));
      send_request(query_at(5'd18, 5'd16));
      send_request(query_at(5'd16, 5'd19));
      send_request(query_at(5'd16, 5'd16));
      // Heading left with hits off, then up with hits mixed.
      send_request(observe_at(5'd10, 5'd20, DIR_LEFT, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
      send_request(observe_at(5'd5, 5'd5, DIR_UP, 8'h30, 8'h40, 8'h50, 1'b0, 1'b1, 1'b0));
      // Same scan again and again: walls climb to the upper limit, robot cell
      // bottoms out at the lower one.
      repeat (3) begin
         send_request(observe_at(5'd16, 5'd16, DIR_RIGHT, 8'h07, 8'h08, 8'h18,
                                 1'b1, 1'b1, 1'b1));
      end
      send_request(query_at(5'd18, 5'd16));
      send_request(query_at(5'd16, 5'd16));
      send_request(query_at(5'd5, 5'd0));
      send_request(query_at(5'd10, 5'd20));

      // Random part: one register setting and one idle mode per phase.
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            settle();
            program_csrs(settings_for_phase(phase));
            if (phase == 5) begin
               write_csr(REG_UNMAPPED, 5'h1F);
            end
            @(negedge clock);
            csr_we    <= 1'b0;
            idle_mode <= idle_mode_type'(phase % 4);
         end
         hot_x = $urandom_range(0, 31);
         hot_y = $urandom_range(0, 31);
         repeat (ITEMS_PER_PHASE) send_request(random_request(hot_x, hot_y));
      end

      settle();
      $display("run covered %0d observe and %0d query transactions over %0d register settings",
               observe_count, query_count, PHASES);
      $display("%0d query results compared, idle modes: none, sender, receiver, both",
               checked_count);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: ends the run once nothing has moved on either channel for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/ogbu_pkg.sv
hdl/ogbu_req_if.sv
hdl/ogbu_rsp_if.sv
hdl/ogbu_belief_mem.sv
hdl/ogbu_sat_alu.sv
hdl/occupancy_grid_beam_update_unit.sv
verif/occupancy_grid_beam_update_unit_checker.sv
verif/occupancy_grid_beam_update_unit_test.sv
